// File: src/mtiu_pkg.sv
// Shared types and codes of the machine trap and timer interrupt unit.
package mtiu_pkg;

	localparam int XLEN      = 64;
	localparam int TIME_W    = 32;
	localparam int CFG_IDX_W = 1;

	// event codes
	localparam logic [2:0] ACT_TICK  = 3'd0;
	localparam logic [2:0] ACT_EXC   = 3'd1;
	localparam logic [2:0] ACT_MRET  = 3'd2;
	localparam logic [2:0] ACT_WFI   = 3'd3;
	localparam logic [2:0] ACT_MATCH = 3'd4;

	// result status codes
	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_SLEEP = 2'd1;
	localparam logic [1:0] ST_TRAP  = 2'd2;
	localparam logic [1:0] ST_HALT  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TRAP_VECTOR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMER_IRQ_EN = 1'b1;

	localparam logic [3:0]      CAUSE_ILLEGAL   = 4'd2;
	localparam logic [3:0]      CAUSE_LOAD_ACC  = 4'd5;
	localparam logic [3:0]      CAUSE_STORE_ACC = 4'd7;
	localparam logic [XLEN-1:0] TIMER_CAUSE     = 64'h0000_0000_8000_0007;
	localparam logic [1:0]      PRIV_M          = 2'd3;
	localparam logic [XLEN-1:0] INSN_BYTES      = 64'd4;

	typedef struct packed {
		logic [2:0]        action;
		logic [TIME_W-1:0] elapsed;
		logic [3:0]        cause_code;
		logic [XLEN-1:0]   fault_value;
		logic [XLEN-1:0]   current_pc;
		logic [XLEN-1:0]   match_value;
	} evt_t;

	typedef struct packed {
		logic [1:0]      status;
		logic [XLEN-1:0] next_pc;
		logic            irq_pending;
		logic [1:0]      priv_level;
	} res_t;

endpackage

// File: src/machine_trap_interrupt_unit_core.sv
// Top level of the machine trap and timer interrupt unit: event and result registers.
// Each event item is registered, evaluated against the trap CSRs and timer state, and its
// result lands in an output register: one event per clock is sustained unless evt_stall.
// The event register loads on acceptance, and the result register loads from it once the
// output is free, so res_valid rises as the result register loads. The output
// register lets the next event be evaluated as the current result is taken; evt_stall
// rises only while a result is held by res_stall and another event already waits in the
// event register.
// Configuration writes are always ready and take effect on the next cycle; write them
// only while no event is in flight.
module machine_trap_interrupt_unit_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                evt_valid,
	output logic                                evt_stall,
	input  mtiu_pkg::evt_t                      evt,
	output logic                                res_valid,
	input  logic                                res_stall,
	output mtiu_pkg::res_t                      res,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mtiu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mtiu_pkg::XLEN-1:0]           cfg_data
);
	import mtiu_pkg::*;

	evt_t evt_s1;
	logic vld_s1;
	res_t res_d;
	res_t res_q;
	logic res_vld_q;
	logic out_free;
	logic fire;
	logic evt_take;

	assign out_free  = !res_vld_q || !res_stall;
	assign fire      = vld_s1 && out_free;
	assign evt_stall = vld_s1 && !out_free;
	assign evt_take  = evt_valid && !evt_stall;
	assign cfg_ready = 1'b1;

	mtiu_trap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.evt       (evt_s1),
		.res       (res_d),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (evt_take)
				vld_s1 <= 1'b1;
			else if (fire)
				vld_s1 <= 1'b0;
			if (fire)
				res_vld_q <= 1'b1;
			else if (out_free)
				res_vld_q <= 1'b0;
		end
	end

	// payload registers: event on accept, result on fire, hold otherwise
	always_ff @(posedge clk) begin
		if (evt_take)
			evt_s1 <= evt;
		if (fire)
			res_q <= res_d;
	end

	assign res_valid = res_vld_q;
	assign res       = res_q;

endmodule

// File: src/mtiu_trap_ctrl.sv
// Trap CSRs, timer state and the per-event update logic.
module mtiu_trap_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                fire,
	input  mtiu_pkg::evt_t                      evt,
	output mtiu_pkg::res_t                      res,
	input  logic                                cfg_we,
	input  logic [mtiu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mtiu_pkg::XLEN-1:0]           cfg_data
);
	import mtiu_pkg::*;

	logic [XLEN-1:0]   tvec_q;
	logic              irq_en_q;
	logic [TIME_W-1:0] time_q, time_d;
	logic [XLEN-1:0]   match_q, match_d;
	logic              pend_q, pend_d;
	logic              wait_q, wait_d;
	logic              mie_q, mie_d;
	logic              mpie_q, mpie_d;
	logic [1:0]        mpp_q, mpp_d;
	logic [1:0]        priv_q, priv_d;
	logic [XLEN-1:0]   mepc_q, mepc_d;
	logic [XLEN-1:0]   mcause_q, mcause_d;
	logic [XLEN-1:0]   mtval_q, mtval_d;

	logic [TIME_W-1:0] time_sum;
	logic              pend_hit;
	logic              take_trap;
	logic [XLEN-1:0]   trap_cause;
	logic [XLEN-1:0]   trap_val;
	logic [1:0]        st;
	logic [XLEN-1:0]   npc;

	assign time_sum = time_q + evt.elapsed;
	assign pend_hit = {{(XLEN-TIME_W){1'b0}}, time_sum} > match_q;

	always_comb begin
		time_d     = time_q;
		match_d    = match_q;
		pend_d     = pend_q;
		wait_d     = wait_q;
		mie_d      = mie_q;
		mpie_d     = mpie_q;
		mpp_d      = mpp_q;
		priv_d     = priv_q;
		mepc_d     = mepc_q;
		mcause_d   = mcause_q;
		mtval_d    = mtval_q;
		take_trap  = 1'b0;
		trap_cause = TIMER_CAUSE;
		trap_val   = '0;
		st         = ST_RUN;
		npc        = evt.current_pc;
		case (evt.action)
			ACT_TICK: begin
				time_d = time_sum;
				pend_d = pend_hit;
				if (pend_hit) begin
					wait_d = 1'b0;
				end
				if (wait_q && !pend_hit) begin
					st = ST_SLEEP;
				end else if (pend_hit && irq_en_q && mie_q) begin
					take_trap = 1'b1;
				end
			end
			ACT_EXC: begin
				if (evt.cause_code == CAUSE_ILLEGAL) begin
					st = ST_HALT;
				end else begin
					take_trap  = 1'b1;
					trap_cause = {{(XLEN-4){1'b0}}, evt.cause_code};
					// causes from load access fault to store access fault (5 to 7) report the faulting address
					if (evt.cause_code >= CAUSE_LOAD_ACC && evt.cause_code <= CAUSE_STORE_ACC)
						trap_val = evt.fault_value;
					else
						trap_val = evt.current_pc;
				end
			end
			ACT_MRET: begin
				mie_d  = mpie_q;
				mpie_d = 1'b1;
				mpp_d  = priv_q;
				priv_d = mpp_q;
				npc    = mepc_q;
			end
			ACT_WFI: begin
				mie_d  = 1'b1;
				wait_d = 1'b1;
				st     = ST_SLEEP;
				npc    = evt.current_pc + INSN_BYTES;
			end
			ACT_MATCH: begin
				match_d = evt.match_value;
			end
			default: begin
			end
		endcase
		if (take_trap) begin
			mcause_d = trap_cause;
			mtval_d  = trap_val;
			mepc_d   = evt.current_pc;
			mpie_d   = mie_q;
			mie_d    = 1'b0;
			mpp_d    = priv_q;
			priv_d   = PRIV_M;
			wait_d   = 1'b0;
			st       = ST_TRAP;
			npc      = tvec_q;
		end
	end

	assign res.status      = st;
	assign res.next_pc     = npc;
	assign res.irq_pending = pend_d;
	assign res.priv_level  = priv_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvec_q   <= '0;
			irq_en_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TRAP_VECTOR:  tvec_q   <= cfg_data;
				REG_TIMER_IRQ_EN: irq_en_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q   <= '0;
			match_q  <= '0;
			pend_q   <= 1'b0;
			wait_q   <= 1'b0;
			mie_q    <= 1'b0;
			mpie_q   <= 1'b0;
			mpp_q    <= 2'd0;
			priv_q   <= PRIV_M;
			mepc_q   <= '0;
			mcause_q <= '0;
			mtval_q  <= '0;
		end else if (fire) begin
			time_q   <= time_d;
			match_q  <= match_d;
			pend_q   <= pend_d;
			wait_q   <= wait_d;
			mie_q    <= mie_d;
			mpie_q   <= mpie_d;
			mpp_q    <= mpp_d;
			priv_q   <= priv_d;
			mepc_q   <= mepc_d;
			mcause_q <= mcause_d;
			mtval_q  <= mtval_d;
		end
	end

`ifndef SYNTHESIS
	a_trap_enters_m: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.status == ST_TRAP |=> priv_q == PRIV_M && !mie_q && !wait_q)
		else $error("trap entry did not switch to machine mode with MIE clear");

	a_exc_cause: assert property (@(posedge clk) disable iff (!arst_n)
		fire && evt.action == ACT_EXC && evt.cause_code != CAUSE_ILLEGAL
		|=> mcause_q == {{(XLEN-4){1'b0}}, $past(evt.cause_code)}
		&& mepc_q == $past(evt.current_pc))
		else $error("exception entry recorded wrong mcause or mepc");

	a_timer_irq_tval: assert property (@(posedge clk) disable iff (!arst_n)
		fire && evt.action == ACT_TICK && res.status == ST_TRAP
		|=> mcause_q == TIMER_CAUSE && mtval_q == '0)
		else $error("timer interrupt entry recorded wrong mcause or mtval");

	a_halt_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.status == ST_HALT
		|=> $stable(mepc_q) && $stable(priv_q) && $stable(mie_q) && $stable(mcause_q))
		else $error("halting exception changed trap state");
`endif

endmodule
